// ----- rtl/nearest_neighbour_rgb565_scaler_assert.svh -----
// assertion macros shared by the scaler rtl
`ifndef NEAREST_NEIGHBOUR_RGB565_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOUR_RGB565_SCALER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define NNS_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("scaler check failed: same-cycle rule");

// next-cycle implication, disabled while in reset
`define NNS_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("scaler check failed: next-cycle rule");

`endif

// ----- rtl/nns_pkg.sv -----
// types, constants and helpers for the nearest neighbour scaler
package nns_pkg;

    localparam int NNS_SRC_WORDS = 65536;
    localparam int NNS_MAX_DIM   = 1024;

    localparam int NNS_CFG_W     = 11;
    localparam int NNS_COORD_W   = 10;
    localparam int NNS_IDX_W     = 16;
    localparam int NNS_CH_W      = 8;
    localparam int NNS_PIX_W     = 24;
    localparam int NNS_OUT_W     = 16;
    localparam int NNS_PROD_W    = NNS_COORD_W + NNS_CFG_W;
    localparam int NNS_Q_W       = NNS_CFG_W;
    localparam int NNS_ADDR_W    = 2 * NNS_CFG_W + 1;
    localparam int NNS_PADDR_W   = 4;
    localparam int NNS_PDATA_W   = 32;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } reg_idx_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROW_START,
        S_ROW_WAIT,
        S_COL_START,
        S_COL_WAIT,
        S_ADDR,
        S_LOOKUP,
        S_READ
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic dim_ok(input logic [NNS_CFG_W-1:0] d);
        return (d != '0) && ({1'b0, d} <= (NNS_CFG_W + 1)'(NNS_MAX_DIM));
    endfunction

    function automatic logic [NNS_OUT_W-1:0] pack565(input logic [NNS_PIX_W-1:0] pix);
        return {pix[23:19], pix[15:10], pix[7:3]};
    endfunction

endpackage

// ----- rtl/nns_ram.sv -----
// generic simple dual-port ram with registered read
module nns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/nns_div.sv -----
// shared restoring divider, one quotient bit per cycle
module nns_div
    import nns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NNS_PROD_W-1:0] dividend,
    input  logic [NNS_CFG_W-1:0]  divisor,
    output logic [NNS_PROD_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(NNS_PROD_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NNS_CFG_W-1:0]  rem_reg, rem_next;
    logic [NNS_PROD_W-1:0] quo_reg, quo_next;
    logic [NNS_CFG_W-1:0]  dsr_reg, dsr_next;
    logic [NNS_CFG_W:0]    trial;
    logic [NNS_CFG_W:0]    diff;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[NNS_PROD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NNS_PROD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[NNS_CFG_W-1:0];
                quo_next = {quo_reg[NNS_PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NNS_CFG_W-1:0];
                quo_next = {quo_reg[NNS_PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/nearest_neighbour_rgb565_scaler.sv -----
// top level of the nearest neighbour rgb888 to rgb565 scaler
//
// requests enter on start while busy is low; operation selects a source pixel
// write (write_index, red, green, blue) or a scaled fetch (out_col, out_row).
// every request gives exactly one result: done is high for one cycle with
// pixel565 and status valid; status 1 flags a bad index, coordinate, size or
// source address, and pixel565 is then 0. the receiver cannot stall, so a
// result is never held back.
// a write, or a fetch rejected for its size or coordinate, is settled in the
// dispatch state, which registers its result. a good fetch has the source row
// and column each divided by one shared restoring divider at one quotient bit
// per cycle, then one multiply-add forms the address and the frame ram gives
// registered read data. busy stays high throughout.
// the four size registers sit on the apb port at 0x0, 0x4, 0x8 and 0xc
// and must be written only while the block is idle; the block does not enforce this.
// reset returns the sequencer to idle and all sizes to 1; the frame ram
// is not cleared and a source entry must be written before it is fetched.
`include "nearest_neighbour_rgb565_scaler_assert.svh"

module nearest_neighbour_rgb565_scaler
    import nns_pkg::*;
#(
    parameter int SRC_WORDS = NNS_SRC_WORDS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    operation,
    input  logic [NNS_IDX_W-1:0]    write_index,
    input  logic [NNS_CH_W-1:0]     red,
    input  logic [NNS_CH_W-1:0]     green,
    input  logic [NNS_CH_W-1:0]     blue,
    input  logic [NNS_COORD_W-1:0]  out_col,
    input  logic [NNS_COORD_W-1:0]  out_row,
    output logic                    done,
    output logic [NNS_OUT_W-1:0]    pixel565,
    output logic                    status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [NNS_PADDR_W-1:0]  paddr,
    input  logic [NNS_PDATA_W-1:0]  pwdata,
    output logic [NNS_PDATA_W-1:0]  prdata,
    output logic                    pready
);

    localparam int AW = $clog2(SRC_WORDS);
    localparam int IW = (AW > NNS_IDX_W) ? AW : NNS_IDX_W;

    // configuration registers
    logic [NNS_CFG_W-1:0] src_width_reg;
    logic [NNS_CFG_W-1:0] src_height_reg;
    logic [NNS_CFG_W-1:0] dst_width_reg;
    logic [NNS_CFG_W-1:0] dst_height_reg;
    logic                 cfg_we;
    reg_idx_t             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= NNS_CFG_W'(1);
            src_height_reg <= NNS_CFG_W'(1);
            dst_width_reg  <= NNS_CFG_W'(1);
            dst_height_reg <= NNS_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[NNS_CFG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[NNS_CFG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[NNS_CFG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[NNS_CFG_W-1:0];
                default:        src_width_reg  <= src_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = NNS_PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = NNS_PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = NNS_PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = NNS_PDATA_W'(dst_height_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer state and request payload
    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    logic                   op_reg, op_next;
    logic [NNS_IDX_W-1:0]   widx_reg, widx_next;
    logic [NNS_PIX_W-1:0]   rgb_reg, rgb_next;
    logic [NNS_COORD_W-1:0] col_reg, col_next;
    logic [NNS_COORD_W-1:0] row_reg, row_next;
    logic [NNS_PROD_W-1:0]  prod_reg, prod_next;
    logic [NNS_Q_W-1:0]     sy_reg, sy_next;
    logic [NNS_Q_W-1:0]     sx_reg, sx_next;
    logic [NNS_ADDR_W-1:0]  addr_reg, addr_next;
    logic [NNS_OUT_W-1:0]   pixel565_reg, pixel565_next;
    logic                   status_reg, status_next;

    logic [NNS_PROD_W-1:0]   row_prod;
    logic [NNS_PROD_W-1:0]   col_prod;
    logic [NNS_ADDR_W-2:0]   addr_prod;
    logic [IW-1:0]           widx_ext;
    logic                    widx_ok;
    logic                    fetch_bad;

    logic                    div_start;
    logic [NNS_CFG_W-1:0]    div_divisor;
    logic [NNS_PROD_W-1:0]   div_quotient;
    div_stat_t               div_stat;

    logic                    mem_we;
    logic                    mem_re;
    logic [NNS_PIX_W-1:0]    mem_rdata;

    assign row_prod  = row_reg * src_height_reg;
    assign col_prod  = col_reg * src_width_reg;
    assign addr_prod = sy_reg * src_width_reg;
    assign widx_ext  = IW'(widx_reg);
    assign widx_ok   = {1'b0, widx_ext} < (IW + 1)'(SRC_WORDS);
    assign fetch_bad = !dim_ok(src_width_reg) || !dim_ok(src_height_reg) ||
                       !dim_ok(dst_width_reg) || !dim_ok(dst_height_reg) ||
                       ({1'b0, col_reg} >= dst_width_reg) ||
                       ({1'b0, row_reg} >= dst_height_reg);

    assign div_divisor = (state_reg == S_ROW_START) ? dst_height_reg : dst_width_reg;

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        widx_next     = widx_reg;
        rgb_next      = rgb_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        prod_next     = prod_reg;
        sy_next       = sy_reg;
        sx_next       = sx_reg;
        addr_next     = addr_reg;
        pixel565_next = pixel565_reg;
        status_next   = status_reg;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    widx_next  = write_index;
                    rgb_next   = {red, green, blue};
                    col_next   = out_col;
                    row_next   = out_row;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (op_t'(op_reg) == OP_WRITE)
                begin
                    mem_we        = widx_ok;
                    done_next     = 1'b1;
                    pixel565_next = '0;
                    status_next   = !widx_ok;
                    state_next    = S_IDLE;
                end
                else if (fetch_bad)
                begin
                    done_next     = 1'b1;
                    pixel565_next = '0;
                    status_next   = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    prod_next  = row_prod;
                    state_next = S_ROW_START;
                end
            end
            S_ROW_START:
            begin
                div_start  = 1'b1;
                state_next = S_ROW_WAIT;
            end
            S_ROW_WAIT:
            begin
                if (div_stat.done)
                begin
                    sy_next    = div_quotient[NNS_Q_W-1:0];
                    prod_next  = col_prod;
                    state_next = S_COL_START;
                end
            end
            S_COL_START:
            begin
                div_start  = 1'b1;
                state_next = S_COL_WAIT;
            end
            S_COL_WAIT:
            begin
                if (div_stat.done)
                begin
                    sx_next    = div_quotient[NNS_Q_W-1:0];
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                addr_next  = NNS_ADDR_W'(addr_prod) + NNS_ADDR_W'(sx_reg);
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                if (addr_reg < NNS_ADDR_W'(SRC_WORDS))
                begin
                    mem_re     = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    done_next     = 1'b1;
                    pixel565_next = '0;
                    status_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                done_next     = 1'b1;
                pixel565_next = pack565(mem_rdata);
                status_next   = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        widx_reg     <= widx_next;
        rgb_reg      <= rgb_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        prod_reg     <= prod_next;
        sy_reg       <= sy_next;
        sx_reg       <= sx_next;
        addr_reg     <= addr_next;
        pixel565_reg <= pixel565_next;
        status_reg   <= status_next;
    end

    nns_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    nns_ram #(
        .WIDTH (NNS_PIX_W),
        .DEPTH (SRC_WORDS)
    ) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata (rgb_reg),
        .re    (mem_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign pixel565 = pixel565_reg;
    assign status   = status_reg;

    `NNS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `NNS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `NNS_ASSERT_NOW(a_error_zero, clk, rst_n, done && status, pixel565 == '0)
    `NNS_ASSERT_NOW(a_div_free, clk, rst_n, div_start, !div_stat.busy && busy)

endmodule

// ----- bench/nns_result_checker.sv -----
// result checker for the scaler: tracks sizes and frame, predicts and compares results
module nns_result_checker
    import nns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    operation,
    input  logic [NNS_IDX_W-1:0]    write_index,
    input  logic [NNS_CH_W-1:0]     red,
    input  logic [NNS_CH_W-1:0]     green,
    input  logic [NNS_CH_W-1:0]     blue,
    input  logic [NNS_COORD_W-1:0]  out_col,
    input  logic [NNS_COORD_W-1:0]  out_row,
    input  logic                    done,
    input  logic [NNS_OUT_W-1:0]    pixel565,
    input  logic                    status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [NNS_PADDR_W-1:0]  paddr,
    input  logic [NNS_PDATA_W-1:0]  pwdata,
    input  logic [NNS_PDATA_W-1:0]  prdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      outstanding
);

    localparam logic [7:0] RED_KEEP   = 8'hF8;
    localparam logic [7:0] GREEN_KEEP = 8'hFC;

    typedef struct packed {
        logic [NNS_OUT_W-1:0] pixel;
        logic                 status;
    } scaled_px_t;

    logic [NNS_CFG_W-1:0] src_w;
    logic [NNS_CFG_W-1:0] src_h;
    logic [NNS_CFG_W-1:0] dst_w;
    logic [NNS_CFG_W-1:0] dst_h;
    logic [NNS_PIX_W-1:0] frame_copy [NNS_SRC_WORDS];
    scaled_px_t           pending_pixels [$];
    scaled_px_t           want;
    logic [NNS_CFG_W-1:0] held;

    initial fail_count = 0;

    function automatic logic size_valid(input logic [NNS_CFG_W-1:0] d);
        return d != 0 && d <= NNS_MAX_DIM;
    endfunction

    // nearest source pixel of an output coordinate, packed to 5-6-5
    function automatic scaled_px_t scale_lookup(input logic [NNS_COORD_W-1:0] col,
                                                input logic [NNS_COORD_W-1:0] row);
        longint unsigned sx;
        longint unsigned sy;
        longint unsigned addr;
        logic [NNS_PIX_W-1:0] pix;
        scaled_px_t r;
        r.pixel = '0;
        r.status = 1'b1;
        if (size_valid(src_w) && size_valid(src_h) && size_valid(dst_w) && size_valid(dst_h)
            && col < dst_w && row < dst_h)
        begin
            sy = (64'(row) * 64'(src_h)) / 64'(dst_h);
            sx = (64'(col) * 64'(src_w)) / 64'(dst_w);
            addr = sy * 64'(src_w) + sx;
            if (addr < NNS_SRC_WORDS)
            begin
                pix = frame_copy[addr];
                r.pixel = (16'(pix[23:16] & RED_KEEP) << 8)
                        | (16'(pix[15:8] & GREEN_KEEP) << 3)
                        | 16'(pix[7:0] >> 3);
                r.status = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w <= 1;
            src_h <= 1;
            dst_w <= 1;
            dst_h <= 1;
            pending_pixels.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result at this edge belongs to an earlier request, so compare first
            if (done)
            begin
                if (pending_pixels.size() == 0)
                    flag_mismatch("result with no request pending", 0, {pixel565, status});
                else
                begin
                    want = pending_pixels.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", want.status, status);
                    if (pixel565 !== want.pixel)
                        flag_mismatch("pixel565", want.pixel, pixel565);
                end
            end

            if (start && !busy)
            begin
                if (operation == OP_WRITE)
                begin
                    want.pixel = '0;
                    want.status = 1'b1;
                    if (write_index < NNS_SRC_WORDS)
                    begin
                        frame_copy[write_index] = {red, green, blue};
                        want.status = 1'b0;
                    end
                end
                else
                    want = scale_lookup(out_col, out_row);
                pending_pixels.push_back(want);
            end

            if (psel && penable && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SRC_WIDTH:  held = src_w;
                    REG_SRC_HEIGHT: held = src_h;
                    REG_DST_WIDTH:  held = dst_w;
                    default:        held = dst_h;
                endcase
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_SRC_WIDTH:  src_w <= pwdata[NNS_CFG_W-1:0];
                        REG_SRC_HEIGHT: src_h <= pwdata[NNS_CFG_W-1:0];
                        REG_DST_WIDTH:  dst_w <= pwdata[NNS_CFG_W-1:0];
                        default:        dst_h <= pwdata[NNS_CFG_W-1:0];
                    endcase
                end
                else if (prdata !== NNS_PDATA_W'(held))
                    flag_mismatch("prdata", NNS_PDATA_W'(held), prdata);
            end

            outstanding <= pending_pixels.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// top of the scaler bench: clock, reset, requests, size programming and verdict
module testbench;
    import nns_pkg::*;

    localparam int ITEMS = 950;
    localparam int CALM_FROM = 850;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    operation;
    logic [NNS_IDX_W-1:0]    write_index;
    logic [NNS_CH_W-1:0]     red;
    logic [NNS_CH_W-1:0]     green;
    logic [NNS_CH_W-1:0]     blue;
    logic [NNS_COORD_W-1:0]  out_col;
    logic [NNS_COORD_W-1:0]  out_row;
    logic                    done;
    logic [NNS_OUT_W-1:0]    pixel565;
    logic                    status;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [NNS_PADDR_W-1:0]  paddr;
    logic [NNS_PDATA_W-1:0]  pwdata;
    logic [NNS_PDATA_W-1:0]  prdata;
    logic                    pready;
    int                      fail_count;
    int                      outstanding;

    // sizes as last programmed, used to aim fetches at written source pixels
    logic [NNS_CFG_W-1:0] sw;
    logic [NNS_CFG_W-1:0] sh;
    logic [NNS_CFG_W-1:0] dw;
    logic [NNS_CFG_W-1:0] dh;
    bit                   loaded [NNS_SRC_WORDS];
    int                   issued;
    bit                   idling;

    nearest_neighbour_rgb565_scaler i_dut (.*);

    nns_result_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

    function automatic logic size_sane(input logic [NNS_CFG_W-1:0] d);
        return d != 0 && d <= NNS_MAX_DIM;
    endfunction

    // true when a fetch of (col, row) would read the frame, with the word it reads
    function automatic bit fetch_target(input logic [NNS_COORD_W-1:0] col,
                                        input logic [NNS_COORD_W-1:0] row,
                                        output int unsigned addr);
        longint unsigned a;
        addr = 0;
        if (!size_sane(sw) || !size_sane(sh) || !size_sane(dw) || !size_sane(dh)
            || col >= dw || row >= dh)
            return 0;
        a = (64'(row) * 64'(sh) / 64'(dh)) * 64'(sw) + 64'(col) * 64'(sw) / 64'(dw);
        if (a >= NNS_SRC_WORDS)
            return 0;
        addr = a;
        return 1;
    endfunction

    task automatic await_accept();
        do @(posedge clk); while (busy);
        issued++;
    endtask

    task automatic rest(input int n);
        start <= 1'b0;
        operation <= $urandom;
        write_index <= $urandom;
        out_col <= $urandom;
        out_row <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_rest();
        if (idling && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 11));
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic issue_write(input logic [NNS_IDX_W-1:0] idx, input logic [NNS_PIX_W-1:0] rgb);
        start <= 1'b1;
        operation <= OP_WRITE;
        write_index <= idx;
        red <= rgb[23:16];
        green <= rgb[15:8];
        blue <= rgb[7:0];
        out_col <= $urandom;
        out_row <= $urandom;
        await_accept();
        loaded[idx] = 1'b1;
    endtask

    task automatic issue_fetch(input logic [NNS_COORD_W-1:0] col,
                               input logic [NNS_COORD_W-1:0] row);
        start <= 1'b1;
        operation <= OP_FETCH;
        write_index <= $urandom;
        red <= $urandom;
        green <= $urandom;
        blue <= $urandom;
        out_col <= col;
        out_row <= row;
        await_accept();
    endtask

    // a fetch whose source pixel is unwritten gets that pixel written first
    task automatic random_fetch(input bit in_box);
        logic [NNS_COORD_W-1:0] col;
        logic [NNS_COORD_W-1:0] row;
        int unsigned addr;
        col = (in_box && size_sane(dw)) ? $urandom_range(dw - 1, 0) : $urandom;
        row = (in_box && size_sane(dh)) ? $urandom_range(dh - 1, 0) : $urandom;
        if (fetch_target(col, row, addr) && !loaded[addr])
        begin
            issue_write(addr[NNS_IDX_W-1:0], $urandom);
            maybe_rest();
        end
        issue_fetch(col, row);
    endtask

    task automatic cfg_access(input bit wr, input reg_idx_t idx, input logic [NNS_CFG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {21'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_sizes(input logic [NNS_CFG_W-1:0] a, input logic [NNS_CFG_W-1:0] b,
                                 input logic [NNS_CFG_W-1:0] c, input logic [NNS_CFG_W-1:0] d);
        hold_until_drained();
        cfg_access(1'b1, REG_SRC_WIDTH, a);
        cfg_access(1'b1, REG_SRC_HEIGHT, b);
        cfg_access(1'b1, REG_DST_WIDTH, c);
        cfg_access(1'b1, REG_DST_HEIGHT, d);
        cfg_access(1'b0, REG_SRC_WIDTH, '0);
        cfg_access(1'b0, REG_SRC_HEIGHT, '0);
        cfg_access(1'b0, REG_DST_WIDTH, '0);
        cfg_access(1'b0, REG_DST_HEIGHT, '0);
        sw = a;
        sh = b;
        dw = c;
        dh = d;
    endtask

    initial
    begin
        logic [NNS_CFG_W-1:0] s [4];
        int kind;
        int n;
        int pick;
        int area;

        rst_n <= 1'b0;
        start <= 1'b0;
        operation <= OP_WRITE;
        write_index <= '0;
        red <= '0;
        green <= '0;
        blue <= '0;
        out_col <= '0;
        out_row <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sw = 1;
        sh = 1;
        dw = 1;
        dh = 1;
        issued = 0;
        idling = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sizes at their reset value of one
        issue_write(0, 24'hFFFFFF);
        issue_fetch(0, 0);
        issue_write(0, 24'h070307);
        issue_fetch(0, 0);
        issue_write(0, 24'hF8FC08);
        issue_fetch(0, 0);
        issue_fetch(1, 0);
        issue_fetch(0, 1);
        issue_fetch(10'h3FF, 10'h3FF);
        hold_until_drained();
        issue_write(16'hFFFF, 24'h123456);

        // largest sizes: the mapped address can leave the frame
        program_sizes(1024, 1024, 1024, 1024);
        issue_fetch(1023, 1023);
        issue_write(63, 24'hA5C33C);
        issue_fetch(63, 0);
        issue_fetch(0, 64);
        issue_fetch(1023, 63);
        issue_fetch(0, 0);

        // zero and oversized registers reject every fetch
        program_sizes(0, 4, 4, 4);
        issue_fetch(0, 0);
        issue_write(5, 24'h00FF00);
        program_sizes(4, 4, 2047, 4);
        issue_fetch(1, 1);
        program_sizes(3, 5, 7, 2);
        repeat (4) random_fetch(1);

        while (issued < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 4; k++)
                s[k] = $urandom_range(1, 32);
            case (kind)
                0: for (int k = 0; k < 4; k++) s[k] = 1024;
                1: s[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
                2: for (int k = 0; k < 4; k++) s[k] = 1;
                3:
                begin
                    s[0] = $urandom_range(1, 8);
                    s[1] = $urandom_range(1, 8);
                    s[2] = $urandom_range(16, 1024);
                    s[3] = $urandom_range(16, 1024);
                end
                4:
                begin
                    s[0] = $urandom_range(256, 1024);
                    s[1] = $urandom_range(1, 64);
                    s[2] = $urandom_range(1, 1024);
                    s[3] = $urandom_range(1, 64);
                end
                default: ;
            endcase
            program_sizes(s[0], s[1], s[2], s[3]);
            idling = issued < CALM_FROM && $urandom_range(0, 3) != 0;
            area = (size_sane(sw) && size_sane(sh)) ? int'(sw) * int'(sh) : 0;
            if (area > NNS_SRC_WORDS)
                area = NNS_SRC_WORDS;
            n = $urandom_range(30, 80);
            repeat (n)
            begin
                if (issued >= CALM_FROM)
                    idling = 0;
                maybe_rest();
                if ($urandom_range(0, 99) < 3)
                    hold_until_drained();
                pick = $urandom_range(0, 99);
                if (pick < 30 && area > 0)
                    issue_write($urandom_range(area - 1, 0), $urandom);
                else if (pick < 40)
                    issue_write($urandom, $urandom);
                else if (pick < 90)
                    random_fetch(1);
                else
                    random_fetch(0);
            end
        end

        hold_until_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/nns_pkg.sv
rtl/nns_ram.sv
rtl/nns_div.sv
rtl/nearest_neighbour_rgb565_scaler.sv
bench/nns_result_checker.sv
bench/testbench.sv
